/* sv/bmt_pkg.sv */
// Shared types, codes and constants of the breakpoint match table.
package bmt_pkg;

    localparam int DEF_ENTRIES = 128;

    localparam int FUNC_W   = 2;
    localparam int DATA_W   = 16;
    localparam int STATUS_W = 2;
    localparam int KIND_W   = 2;

    // Slot word: {is_line, block, key}; key is the offset of a location slot
    // or the line of a line slot.
    localparam int ENTRY_W  = 1 + 2 * DATA_W;

    localparam logic [FUNC_W-1:0] FUNC_ADD_LINE = 2'd0;
    localparam logic [FUNC_W-1:0] FUNC_ADD_LOC  = 2'd1;
    localparam logic [FUNC_W-1:0] FUNC_FETCH    = 2'd2;

    localparam logic [STATUS_W-1:0] ST_ADDED = 2'd0;
    localparam logic [STATUS_W-1:0] ST_FULL  = 2'd1;
    localparam logic [STATUS_W-1:0] ST_FETCH = 2'd2;

    localparam logic [KIND_W-1:0] KIND_NONE = 2'd0;
    localparam logic [KIND_W-1:0] KIND_LOC  = 2'd1;
    localparam logic [KIND_W-1:0] KIND_LINE = 2'd2;

    typedef enum logic [1:0] {
        FSM_IDLE,
        FSM_SCAN,
        FSM_DRAIN,
        FSM_RESULT
    } fsm_state_t;

    typedef struct packed {
        logic capture;
        logic rd_en;
        logic load_out;
    } ctrl_cmd_t;

    typedef struct packed {
        logic in_scan;
        logic scan_last;
        logic out_free;
    } dp_stat_t;

endpackage

/* sv/bmt_ram.sv */
// Generic single-write, single-read RAM with registered read data.
module bmt_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                                       clk,
    input  logic                                       we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                           wdata,
    input  logic                                       re,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                           rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk) begin
        if (we) begin
            mem_reg[waddr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

/* sv/bmt_ctrl.sv */
// Controller state machine: sequences capture, slot scan and result load.
module bmt_ctrl (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  bmt_pkg::dp_stat_t  stat,
    output bmt_pkg::ctrl_cmd_t cmd
);

    import bmt_pkg::*;

    fsm_state_t state_reg;
    fsm_state_t state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= FSM_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            FSM_IDLE: begin
                if (s_valid) begin
                    state_next = stat.in_scan ? FSM_SCAN : FSM_RESULT;
                end
            end
            FSM_SCAN: begin
                if (stat.scan_last) begin
                    state_next = FSM_DRAIN;
                end
            end
            FSM_DRAIN: begin
                state_next = FSM_RESULT;
            end
            FSM_RESULT: begin
                if (stat.out_free) begin
                    state_next = FSM_IDLE;
                end
            end
            default: begin
                state_next = FSM_IDLE;
            end
        endcase
    end

    always_comb begin
        s_ready      = 1'b0;
        cmd.capture  = 1'b0;
        cmd.rd_en    = 1'b0;
        cmd.load_out = 1'b0;
        case (state_reg)
            FSM_IDLE: begin
                s_ready     = 1'b1;
                cmd.capture = s_valid;
            end
            FSM_SCAN: begin
                cmd.rd_en = 1'b1;
            end
            FSM_RESULT: begin
                cmd.load_out = stat.out_free;
            end
            default: begin
                s_ready = 1'b0;
            end
        endcase
    end

endmodule

/* sv/bmt_dp.sv */
// Datapath: item capture, slot RAM, fill count, compare and result register.
module bmt_dp #(
    parameter int ENTRIES = bmt_pkg::DEF_ENTRIES
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  bmt_pkg::ctrl_cmd_t             cmd,
    output bmt_pkg::dp_stat_t              stat,
    input  logic [bmt_pkg::FUNC_W-1:0]     s_func,
    input  logic [bmt_pkg::DATA_W-1:0]     s_line_number,
    input  logic [bmt_pkg::DATA_W-1:0]     s_code_block,
    input  logic [bmt_pkg::DATA_W-1:0]     s_code_offset,
    input  logic                           s_has_source,
    input  logic                           s_line_known,
    output logic                           m_valid,
    input  logic                           m_ready,
    output logic [bmt_pkg::STATUS_W-1:0]   m_status,
    output logic                           m_hit,
    output logic [bmt_pkg::KIND_W-1:0]     m_hit_kind,
    output logic [bmt_pkg::DATA_W-1:0]     m_hit_offset,
    output logic [bmt_pkg::DATA_W-1:0]     m_hit_line
);

    import bmt_pkg::*;

    localparam int AW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int CW = $clog2(ENTRIES + 1);

    // captured item
    logic [FUNC_W-1:0] func_reg;
    logic [DATA_W-1:0] line_reg;
    logic [DATA_W-1:0] block_reg;
    logic [DATA_W-1:0] offset_reg;
    logic              has_src_reg;
    logic              known_reg;

    logic [CW-1:0]     count_reg;
    logic [AW-1:0]     idx_reg;
    logic              rd_vld_reg;
    logic              loc_hit_reg;
    logic              line_hit_reg;
    logic [DATA_W-1:0] last_line_reg;

    logic                m_valid_reg;
    logic [STATUS_W-1:0] m_status_reg;
    logic [KIND_W-1:0]   m_kind_reg;
    logic [DATA_W-1:0]   m_off_reg;
    logic [DATA_W-1:0]   m_line_reg;

    logic [DATA_W-1:0]  eff_off;
    logic [DATA_W-1:0]  eff_line;
    logic [ENTRY_W-1:0] rdata;
    logic [ENTRY_W-1:0] wdata;
    logic               rd_is_line;
    logic [DATA_W-1:0]  rd_block;
    logic [DATA_W-1:0]  rd_key;
    logic               loc_match;
    logic               line_match;
    logic               full;
    logic               is_add;
    logic               ram_we;
    logic [STATUS_W-1:0] res_status;
    logic [KIND_W-1:0]   res_kind;

    assign eff_off  = known_reg ? offset_reg : '0;
    assign eff_line = known_reg ? line_reg : '0;
    assign full     = (count_reg == CW'(ENTRIES));
    assign is_add   = (func_reg == FUNC_ADD_LINE) || (func_reg == FUNC_ADD_LOC);
    assign ram_we   = cmd.load_out && is_add && !full;

    assign wdata = (func_reg == FUNC_ADD_LINE) ? {1'b1, {DATA_W{1'b0}}, line_reg}
                                               : {1'b0, block_reg, offset_reg};

    bmt_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (ENTRIES)
    ) u_slots (
        .clk   (aclk),
        .we    (ram_we),
        .waddr (count_reg[AW-1:0]),
        .wdata (wdata),
        .re    (cmd.rd_en),
        .raddr (idx_reg),
        .rdata (rdata)
    );

    assign rd_is_line = rdata[ENTRY_W-1];
    assign rd_block   = rdata[2*DATA_W-1:DATA_W];
    assign rd_key     = rdata[DATA_W-1:0];
    assign line_match = rd_is_line && (rd_key != '0) && (rd_key == eff_line);
    assign loc_match  = !rd_is_line && (rd_block == block_reg) && (rd_key == eff_off);

    assign stat.in_scan   = (s_func == FUNC_FETCH) && s_has_source && (count_reg != '0);
    assign stat.scan_last = (CW'(idx_reg) == count_reg - CW'(1));
    assign stat.out_free  = !m_valid_reg || m_ready;

    always_comb begin
        res_status = ST_FETCH;
        res_kind   = KIND_NONE;
        case (func_reg)
            FUNC_ADD_LINE, FUNC_ADD_LOC: begin
                res_status = full ? ST_FULL : ST_ADDED;
            end
            FUNC_FETCH: begin
                if (has_src_reg) begin
                    if (loc_hit_reg) begin
                        res_kind = KIND_LOC;
                    end else if (line_hit_reg && (eff_line != '0)
                                 && (eff_line != last_line_reg)) begin
                        res_kind = KIND_LINE;
                    end
                end
            end
            default: begin
                res_status = ST_FETCH;
            end
        endcase
    end

    // control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg     <= '0;
            idx_reg       <= '0;
            rd_vld_reg    <= 1'b0;
            loc_hit_reg   <= 1'b0;
            line_hit_reg  <= 1'b0;
            last_line_reg <= '0;
            m_valid_reg   <= 1'b0;
        end else begin
            rd_vld_reg <= cmd.rd_en;
            if (cmd.capture) begin
                idx_reg      <= '0;
                loc_hit_reg  <= 1'b0;
                line_hit_reg <= 1'b0;
            end else begin
                if (cmd.rd_en) begin
                    idx_reg <= idx_reg + AW'(1);
                end
                if (rd_vld_reg) begin
                    loc_hit_reg  <= loc_hit_reg || loc_match;
                    line_hit_reg <= line_hit_reg || line_match;
                end
            end
            if (ram_we) begin
                count_reg <= count_reg + CW'(1);
            end
            if (cmd.load_out && (res_kind == KIND_LINE)) begin
                last_line_reg <= eff_line;
            end
            if (cmd.load_out) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    // payload
    always_ff @(posedge aclk) begin
        if (cmd.capture) begin
            func_reg    <= s_func;
            line_reg    <= s_line_number;
            block_reg   <= s_code_block;
            offset_reg  <= s_code_offset;
            has_src_reg <= s_has_source;
            known_reg   <= s_line_known;
        end
        if (cmd.load_out) begin
            m_status_reg <= res_status;
            m_kind_reg   <= res_kind;
            m_off_reg    <= (res_kind != KIND_NONE) ? eff_off : '0;
            m_line_reg   <= (res_kind != KIND_NONE) ? eff_line : '0;
        end
    end

    assign m_valid      = m_valid_reg;
    assign m_status     = m_status_reg;
    assign m_hit        = (m_kind_reg != KIND_NONE);
    assign m_hit_kind   = m_kind_reg;
    assign m_hit_offset = m_off_reg;
    assign m_hit_line   = m_line_reg;

endmodule

/* sv/breakpoint_match_table.sv */
// Top level of the breakpoint match table: controller plus datapath.
//
// Usage: one input channel (s_*) carries items, one result channel (m_*)
// carries results; both transfer on valid and ready high at a rising edge.
// Every item yields exactly one result, in order.
//   s_func = add line / add location: store the breakpoint in the next free
//     slot (slots fill in order and are never freed); status reports added
//     or table full.
//   s_func = fetch: walk the filled slots through the slot RAM, one slot per
//     cycle, then report a location hit, a new-line hit or a miss. The walk
//     is skipped when no slot is filled or the fetch has no source; the
//     slot RAM has a single read port, so slots are read one at a time.
// One item is in work at a time; s_ready is high while the controller idles.
// The result register decouples the sides: the next item transfers while a
// result still waits, and a stalled receiver only holds back the result
// load of the following item.
// Reset (aresetn low, synchronous) empties the table at once via the fill
// count, clears the last break line and drops any pending result; no
// clearing pass is needed.
module breakpoint_match_table #(
    parameter int ENTRIES = bmt_pkg::DEF_ENTRIES
) (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         s_valid,
    output logic                         s_ready,
    input  logic [bmt_pkg::FUNC_W-1:0]   s_func,
    input  logic [bmt_pkg::DATA_W-1:0]   s_line_number,
    input  logic [bmt_pkg::DATA_W-1:0]   s_code_block,
    input  logic [bmt_pkg::DATA_W-1:0]   s_code_offset,
    input  logic                         s_has_source,
    input  logic                         s_line_known,
    output logic                         m_valid,
    input  logic                         m_ready,
    output logic [bmt_pkg::STATUS_W-1:0] m_status,
    output logic                         m_hit,
    output logic [bmt_pkg::KIND_W-1:0]   m_hit_kind,
    output logic [bmt_pkg::DATA_W-1:0]   m_hit_offset,
    output logic [bmt_pkg::DATA_W-1:0]   m_hit_line
);

    import bmt_pkg::*;

    // commands down to the datapath, status back up
    ctrl_cmd_t cmd;
    dp_stat_t  stat;

    // sequence capture, slot walk and result load
    bmt_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .stat    (stat),
        .cmd     (cmd)
    );

    // hold the slots, compare and register the result
    bmt_dp #(
        .ENTRIES (ENTRIES)
    ) u_dp (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cmd           (cmd),
        .stat          (stat),
        .s_func        (s_func),
        .s_line_number (s_line_number),
        .s_code_block  (s_code_block),
        .s_code_offset (s_code_offset),
        .s_has_source  (s_has_source),
        .s_line_known  (s_line_known),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_status      (m_status),
        .m_hit         (m_hit),
        .m_hit_kind    (m_hit_kind),
        .m_hit_offset  (m_hit_offset),
        .m_hit_line    (m_hit_line)
    );

endmodule

/* sv/bmt_checker.sv */
// Port-level checker for the breakpoint match table, bound to the top level.
module bmt_checker (
    input logic                         aclk,
    input logic                         aresetn,
    input logic                         m_valid,
    input logic                         m_ready,
    input logic [bmt_pkg::STATUS_W-1:0] m_status,
    input logic                         m_hit,
    input logic [bmt_pkg::KIND_W-1:0]   m_hit_kind,
    input logic [bmt_pkg::DATA_W-1:0]   m_hit_offset,
    input logic [bmt_pkg::DATA_W-1:0]   m_hit_line
);

    import bmt_pkg::*;

    // a stalled result holds
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_status) && $stable(m_hit_kind)
            && $stable(m_hit_offset) && $stable(m_hit_line))
        else $error("result changed while stalled");

    // no result is pending right after reset
    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result valid after reset");

    // a miss reports zero location and kind none
    a_miss_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_hit |-> (m_hit_kind == KIND_NONE) && (m_hit_offset == '0)
            && (m_hit_line == '0))
        else $error("miss carries nonzero hit fields");

    // only fetch results may hit
    a_hit_fetch: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_hit |-> (m_status == ST_FETCH)
            && ((m_hit_kind == KIND_LOC) || (m_hit_kind == KIND_LINE)))
        else $error("hit on a non-fetch result");

    // a line break always names a nonzero line
    a_line_nonzero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && (m_hit_kind == KIND_LINE) |-> (m_hit_line != '0))
        else $error("line break with line zero");

endmodule

bind breakpoint_match_table bmt_checker u_bmt_checker (.*);
